// ===== rtl/core/pngunf_pkg.sv =====
package pngunf_pkg;

  // default sizes
  localparam int MAX_ROW_BYTES_DEF   = 8192;
  localparam int MAX_PIXEL_BYTES_DEF = 8;

  // field and register widths
  localparam int BYTE_W      = 8;
  localparam int ROW_BYTES_W = 14;
  localparam int BPP_W       = 4;
  localparam int ROWS_W      = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BPP        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS = 2'd2;

  // row filter types
  typedef enum logic [BYTE_W-1:0] {
    FILT_NONE  = 8'd0,
    FILT_SUB   = 8'd1,
    FILT_UP    = 8'd2,
    FILT_AVG   = 8'd3,
    FILT_PAETH = 8'd4
  } filt_t;

  // paeth predictor, left a, upper b, upper-left c
  function automatic logic [BYTE_W-1:0] paeth(input logic [BYTE_W-1:0] a,
                                              input logic [BYTE_W-1:0] b,
                                              input logic [BYTE_W-1:0] c);
    logic signed [9:0] dbc;
    logic signed [9:0] dac;
    logic signed [9:0] dsum;
    logic [9:0] pa;
    logic [9:0] pb;
    logic [9:0] pc;
    dbc  = $signed({2'b00, b}) - $signed({2'b00, c});
    dac  = $signed({2'b00, a}) - $signed({2'b00, c});
    dsum = dbc + dac;
    pa   = dbc[9]  ? 10'(-dbc)  : 10'(dbc);
    pb   = dac[9]  ? 10'(-dac)  : 10'(dac);
    pc   = dsum[9] ? 10'(-dsum) : 10'(dsum);
    if (pa <= pb && pa <= pc) begin
      return a;
    end else if (pb <= pc) begin
      return b;
    end else begin
      return c;
    end
  endfunction

endpackage

// ===== rtl/core/png_row_unfilter.sv =====
// png scanline unfilter. takes the inflated, filtered png stream one beat per
// byte; the first byte of a row is the filter type and yields no output beat,
// every data byte yields one reconstructed byte (none, sub, up, average or
// paeth prediction added modulo 256). the block sustains one byte per cycle
// unless the output stalls; a data byte's result passes the line buffer read
// (a single-port-per-side memory with registered read data), then the output
// register. the line buffer holding the previous row is not cleared after
// reset: the first row of an image ignores it. the user must write row_bytes,
// bytes_per_pixel and image_rows through the cfg port only while the block is
// idle; the block does not enforce it. zero acts as one and oversized values
// are clamped to the buffer sizes. bad_filter flags every byte of a row whose
// filter type is above four, the prediction then being zero.
module png_row_unfilter #(
  parameter int MAX_ROW_BYTES   = pngunf_pkg::MAX_ROW_BYTES_DEF,
  parameter int MAX_PIXEL_BYTES = pngunf_pkg::MAX_PIXEL_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // filtered byte stream
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [pngunf_pkg::BYTE_W-1:0]    in_filtered_byte,
  // reconstructed byte stream
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [pngunf_pkg::BYTE_W-1:0]    out_pixel_byte,
  output logic                             out_end_of_row,
  output logic                             out_end_of_image,
  output logic                             out_bad_filter,
  // register writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pngunf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pngunf_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int PW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
  localparam int BW = pngunf_pkg::BYTE_W;
  localparam int RW = pngunf_pkg::ROWS_W;
  localparam int XW = 17; // wide enough for any column or row length compare

  // configuration, held as effective value minus one where it helps
  logic [CW-1:0] rb_m1_r;
  logic [PW-1:0] bpp_m1_r;
  logic [RW-1:0] rows_r;

  // position in the stream
  logic          expect_filter_r;
  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic [BW-1:0] row_filt_r;

  // stage 1: line buffer read returning
  logic          s1_valid_r;
  logic [CW-1:0] s1_col_r;
  logic [BW-1:0] s1_byte_r;
  logic [BW-1:0] s1_filt_r;
  logic          s1_edge_r;
  logic          s1_first_r;
  logic          s1_eor_r;
  logic          s1_eoi_r;

  // line buffer and pixel histories
  logic [BW-1:0] line_mem [MAX_ROW_BYTES];
  logic [BW-1:0] mem_rdata_r;
  logic [BW-1:0] left_hist_r [MAX_PIXEL_BYTES];
  logic [BW-1:0] ul_hist_r   [MAX_PIXEL_BYTES];

  // output register
  logic          out_valid_r;
  logic [BW-1:0] out_byte_r;
  logic          out_eor_r;
  logic          out_eoi_r;
  logic          out_bad_r;

  logic          s1_adv;
  logic          in_acc;
  logic          data_acc;
  logic          filt_acc;
  logic          eor;
  logic          eoi;
  logic [RW-1:0] row_inc;
  logic [RW-1:0] rows_eff;
  logic          edge_now;

  logic [BW-1:0] a_val;
  logic [BW-1:0] b_val;
  logic [BW-1:0] c_val;
  logic [BW-1:0] pred;
  logic [8:0]    ab_sum;
  logic          bad;
  logic [BW-1:0] res;

  logic [XW-1:0]                       cfg_rb_ext;
  logic [XW-1:0]                       cfg_rb_m1;
  logic [pngunf_pkg::BPP_W-1:0]        cfg_bpp;
  logic [CW-1:0]                       rb_m1_nxt;
  logic [PW-1:0]                       bpp_m1_nxt;

  // handshakes: stage 1 moves on when the output register is free or draining
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;
  assign filt_acc = in_acc && expect_filter_r;
  assign data_acc = in_acc && !expect_filter_r;
  assign cfg_ready = 1'b1;

  // register write decode, zero acts as one, oversize is clamped
  always_comb begin
    cfg_rb_ext = XW'(cfg_data[pngunf_pkg::ROW_BYTES_W-1:0]);
    cfg_rb_m1  = cfg_rb_ext - XW'(1);
    cfg_bpp    = cfg_data[pngunf_pkg::BPP_W-1:0];
    if (cfg_rb_ext == '0) begin
      rb_m1_nxt = '0;
    end else if (cfg_rb_ext > XW'(MAX_ROW_BYTES)) begin
      rb_m1_nxt = CW'(MAX_ROW_BYTES - 1);
    end else begin
      rb_m1_nxt = CW'(cfg_rb_m1);
    end
    if (cfg_bpp == '0) begin
      bpp_m1_nxt = '0;
    end else if (5'(cfg_bpp) > 5'(MAX_PIXEL_BYTES)) begin
      bpp_m1_nxt = PW'(MAX_PIXEL_BYTES - 1);
    end else begin
      bpp_m1_nxt = PW'(cfg_bpp - pngunf_pkg::BPP_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rb_m1_r  <= '0;
      bpp_m1_r <= '0;
      rows_r   <= RW'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pngunf_pkg::CFG_ROW_BYTES:  rb_m1_r  <= rb_m1_nxt;
        pngunf_pkg::CFG_BPP:        bpp_m1_r <= bpp_m1_nxt;
        pngunf_pkg::CFG_IMAGE_ROWS: rows_r   <= cfg_data[RW-1:0];
        default: ;
      endcase
    end
  end

  // row and image ends, decided as the byte is taken
  always_comb begin
    rows_eff = (rows_r == '0) ? RW'(1) : rows_r;
    row_inc  = row_r + RW'(1);
    eor      = (col_r >= rb_m1_r);
    eoi      = eor && ((row_inc >= rows_eff) || (row_inc == '0));
    edge_now = (XW'(col_r) <= XW'(bpp_m1_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_filter_r <= 1'b1;
      col_r           <= '0;
      row_r           <= '0;
      row_filt_r      <= '0;
    end else if (filt_acc) begin
      expect_filter_r <= 1'b0;
      row_filt_r      <= in_filtered_byte;
    end else if (data_acc) begin
      if (eor) begin
        expect_filter_r <= 1'b1;
        col_r           <= '0;
        row_r           <= eoi ? '0 : row_inc;
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

  // line buffer: read on the data beat, write back when stage 1 retires.
  // a column is read again only a full row later, after its write
  always_ff @(posedge clk) begin
    if (data_acc) begin
      mem_rdata_r <= line_mem[col_r];
    end
    if (s1_adv) begin
      line_mem[s1_col_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (data_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (data_acc) begin
      s1_col_r   <= col_r;
      s1_byte_r  <= in_filtered_byte;
      s1_filt_r  <= row_filt_r;
      s1_edge_r  <= edge_now;
      s1_first_r <= (row_r == '0);
      s1_eor_r   <= eor;
      s1_eoi_r   <= eoi;
    end
  end

  // neighbours and prediction
  always_comb begin
    a_val  = s1_edge_r ? '0 : left_hist_r[bpp_m1_r];
    b_val  = s1_first_r ? '0 : mem_rdata_r;
    c_val  = (s1_edge_r || s1_first_r) ? '0 : ul_hist_r[bpp_m1_r];
    ab_sum = {1'b0, a_val} + {1'b0, b_val};
    bad    = 1'b0;
    case (s1_filt_r)
      pngunf_pkg::FILT_NONE:  pred = '0;
      pngunf_pkg::FILT_SUB:   pred = a_val;
      pngunf_pkg::FILT_UP:    pred = b_val;
      pngunf_pkg::FILT_AVG:   pred = ab_sum[8:1];
      pngunf_pkg::FILT_PAETH: pred = pngunf_pkg::paeth(a_val, b_val, c_val);
      default: begin
        pred = '0;
        bad  = 1'b1;
      end
    endcase
    res = s1_byte_r + pred;
  end

  // histories of the last reconstructed and upper bytes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        left_hist_r[i] <= '0;
        ul_hist_r[i]   <= '0;
      end
    end else if (s1_adv) begin
      for (int i = MAX_PIXEL_BYTES - 1; i > 0; i--) begin
        left_hist_r[i] <= left_hist_r[i-1];
        ul_hist_r[i]   <= ul_hist_r[i-1];
      end
      left_hist_r[0] <= res;
      ul_hist_r[0]   <= b_val;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_byte_r <= res;
      out_eor_r  <= s1_eor_r;
      out_eoi_r  <= s1_eoi_r;
      out_bad_r  <= bad;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_byte   = out_byte_r;
  assign out_end_of_row   = out_eor_r;
  assign out_end_of_image = out_eoi_r;
  assign out_bad_filter   = out_bad_r;

  // input stalls only with both the stage and the output register full
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && s1_valid_r))
    else $error("input stalled with a free slot");

  // image end only on a row end
  a_eoi_eor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_eoi_r) |-> out_eor_r)
    else $error("end of image without end of row");

  // a data beat always lands in stage 1
  a_data_s1: assert property (@(posedge clk) disable iff (!rst_n)
    data_acc |=> s1_valid_r)
    else $error("data beat lost before stage 1");

  // a filter beat is never followed by a filter expectation
  a_filt_data: assert property (@(posedge clk) disable iff (!rst_n)
    filt_acc |=> !expect_filter_r)
    else $error("filter beat did not open a row");

endmodule

// ===== test/png_row_unfilter_tb.sv =====
module png_row_unfilter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BW         = pngunf_pkg::BYTE_W;
  localparam int LINE_MAX   = pngunf_pkg::MAX_ROW_BYTES_DEF;
  localparam int PIX_MAX    = pngunf_pkg::MAX_PIXEL_BYTES_DEF;
  localparam int IDX_W      = pngunf_pkg::CFG_IDX_W;
  localparam int DATA_W     = pngunf_pkg::CFG_DATA_W;
  localparam int RB_W       = pngunf_pkg::ROW_BYTES_W;
  localparam int PX_W       = pngunf_pkg::BPP_W;
  localparam int ROWS_W     = pngunf_pkg::ROWS_W;
  // cycles without any beat on any port before the run is abandoned
  localparam int STALL_LIMIT = 3000;
  // length of the deliberate long hold-off on the output side
  localparam int HOLD_CYCLES = 400;

  // one reconstructed byte as it should leave the block
  typedef struct {
    logic [BW-1:0] pixel_byte;
    logic          end_of_row;
    logic          end_of_image;
    logic          bad_filter;
  } pixel_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [BW-1:0]     in_filtered_byte = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [BW-1:0]     out_pixel_byte;
  logic              out_end_of_row;
  logic              out_end_of_image;
  logic              out_bad_filter;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;

  // bytes waiting to be offered, and reconstructed bytes still owed
  logic [BW-1:0] pending_bytes[$];
  pixel_beat_t   expected_pixels[$];

  // idling mix, percent of cycles
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        long_hold = 1'b0;
  logic        hold_started = 1'b0;
  int          hold_left = 0;
  int          errors = 0;

  // mirror of the block: registers, line buffer, pixel histories, counters
  logic [RB_W-1:0]   row_bytes_cfg = RB_W'(1);
  logic [PX_W-1:0]   bpp_cfg = PX_W'(1);
  logic [ROWS_W-1:0] rows_cfg = ROWS_W'(1);
  logic [BW-1:0]     line_buf[LINE_MAX];
  logic [BW-1:0]     left_hist[PIX_MAX];
  logic [BW-1:0]     upleft_hist[PIX_MAX];
  int                col_count = 0;
  logic [ROWS_W-1:0] row_count = '0;
  logic [BW-1:0]     row_filter = '0;

  png_row_unfilter dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_filtered_byte (in_filtered_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_byte   (out_pixel_byte),
    .out_end_of_row   (out_end_of_row),
    .out_end_of_image (out_end_of_image),
    .out_bad_filter   (out_bad_filter),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // zero acts as one, oversized rows clamp to the line buffer
  function automatic int row_len(input logic [RB_W-1:0] v);
    if (v == 0) return 1;
    return (v > LINE_MAX) ? LINE_MAX : int'(v);
  endfunction

  function automatic int pix_len(input logic [PX_W-1:0] v);
    if (v == 0) return 1;
    return (v > PIX_MAX) ? PIX_MAX : int'(v);
  endfunction

  function automatic int image_len(input logic [ROWS_W-1:0] v);
    return (v == 0) ? 1 : int'(v);
  endfunction

  function automatic void set_reg(input logic [IDX_W-1:0] idx,
                                  input logic [DATA_W-1:0] val);
    case (idx)
      pngunf_pkg::CFG_ROW_BYTES:  row_bytes_cfg = val[RB_W-1:0];
      pngunf_pkg::CFG_BPP:        bpp_cfg = val[PX_W-1:0];
      pngunf_pkg::CFG_IMAGE_ROWS: rows_cfg = val[ROWS_W-1:0];
      default: ;
    endcase
  endfunction

  // works out what one accepted byte yields; filter bytes only set the row mode
  function automatic void unfilter_byte(input logic [BW-1:0] x);
    int rb, bpp, j, a, b, c, pred, p, pa, pb, pc;
    logic first_row, at_edge, bad;
    logic [BW-1:0] res;
    pixel_beat_t beat;
    if (col_count == 0) begin
      row_filter = x;
      col_count = 1;
      return;
    end
    rb = row_len(row_bytes_cfg);
    bpp = pix_len(bpp_cfg);
    j = col_count - 1;
    if (j >= LINE_MAX) j = LINE_MAX - 1;
    // neighbours outside the image count as zero
    first_row = (row_count == 0);
    at_edge = (j < bpp);
    a = at_edge ? 0 : int'(left_hist[bpp-1]);
    b = first_row ? 0 : int'(line_buf[j]);
    c = (at_edge || first_row) ? 0 : int'(upleft_hist[bpp-1]);
    bad = 1'b0;
    case (row_filter)
      pngunf_pkg::FILT_NONE:  pred = 0;
      pngunf_pkg::FILT_SUB:   pred = a;
      pngunf_pkg::FILT_UP:    pred = b;
      pngunf_pkg::FILT_AVG:   pred = (a + b) / 2;
      pngunf_pkg::FILT_PAETH: begin
        p = a + b - c;
        pa = (p > a) ? p - a : a - p;
        pb = (p > b) ? p - b : b - p;
        pc = (p > c) ? p - c : c - p;
        if (pa <= pb && pa <= pc) pred = a;
        else if (pb <= pc) pred = b;
        else pred = c;
      end
      default: begin
        pred = 0;
        bad = 1'b1;
      end
    endcase
    res = BW'(int'(x) + pred);
    for (int i = PIX_MAX - 1; i > 0; i--) begin
      left_hist[i] = left_hist[i-1];
      upleft_hist[i] = upleft_hist[i-1];
    end
    left_hist[0] = res;
    upleft_hist[0] = BW'(b);
    line_buf[j] = res;
    beat.pixel_byte = res;
    beat.end_of_row = 1'b0;
    beat.end_of_image = 1'b0;
    beat.bad_filter = bad;
    if (j + 1 >= rb) begin
      beat.end_of_row = 1'b1;
      col_count = 0;
      row_count = row_count + 1'b1;
      if (int'(row_count) >= image_len(rows_cfg) || row_count == 0) begin
        beat.end_of_image = 1'b1;
        row_count = '0;
      end
    end else begin
      col_count = j + 2;
    end
    expected_pixels.push_back(beat);
  endfunction

  function automatic logic [BW-1:0] pick_filter();
    int unsigned r;
    r = $urandom_range(19);
    // mostly the five known types, now and then an unknown one
    if (r < 19) return BW'(r % 5);
    return BW'($urandom_range(5, 255));
  endfunction

  // whole images of random rows until at least min_items bytes are queued
  task automatic queue_images(input logic [DATA_W-1:0] rb_w,
                              input logic [DATA_W-1:0] rows_w,
                              input int min_items);
    int rb, rows, n;
    rb = row_len(rb_w[RB_W-1:0]);
    rows = image_len(rows_w[ROWS_W-1:0]);
    n = 0;
    while (n < min_items) begin
      for (int r = 0; r < rows; r++) begin
        pending_bytes.push_back(pick_filter());
        for (int k = 0; k < rb; k++) pending_bytes.push_back(BW'($urandom_range(255)));
        n += rb + 1;
      end
    end
  endtask

  // register writes back to back, valid stays high across the group
  task automatic write_config(input logic [2:0] sel, input logic [DATA_W-1:0] rb_w,
                              input logic [DATA_W-1:0] bpp_w,
                              input logic [DATA_W-1:0] rows_w);
    logic [IDX_W-1:0]  idx[3];
    logic [DATA_W-1:0] val[3];
    idx = '{pngunf_pkg::CFG_ROW_BYTES, pngunf_pkg::CFG_BPP, pngunf_pkg::CFG_IMAGE_ROWS};
    val = '{rb_w, bpp_w, rows_w};
    for (int i = 0; i < 3; i++) begin
      if (sel[i]) begin
        cfg_index <= idx[i];
        cfg_data <= val[i];
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        set_reg(idx[i], val[i]);
      end
    end
    cfg_valid <= 1'b0;
  endtask

  // everything offered and every owed byte back, then a pause for a trailing
  // filter byte to settle inside the block
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_bytes.size() != 0 || in_valid || expected_pixels.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  // input driver: a stalled beat is held, otherwise the next byte or a gap
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) unfilter_byte(in_filtered_byte);
      if (!in_valid || !in_stall) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_filtered_byte <= pending_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor: checks each beat against the oldest owed byte, drives stall
  always @(posedge clk) begin : out_side
    pixel_beat_t want;
    logic        stall_now;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected beat: pixel_byte %0h", out_pixel_byte);
          errors++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_pixel_byte !== want.pixel_byte) begin
            $error("pixel_byte: expected %0h, got %0h", want.pixel_byte, out_pixel_byte);
            errors++;
          end
          if (out_end_of_row !== want.end_of_row) begin
            $error("end_of_row: expected %0b, got %0b", want.end_of_row, out_end_of_row);
            errors++;
          end
          if (out_end_of_image !== want.end_of_image) begin
            $error("end_of_image: expected %0b, got %0b", want.end_of_image,
                   out_end_of_image);
            errors++;
          end
          if (out_bad_filter !== want.bad_filter) begin
            $error("bad_filter: expected %0b, got %0b", want.bad_filter, out_bad_filter);
            errors++;
          end
        end
      end
      // one long hold-off so that the block backs up and stalls its input
      if (long_hold && !hold_started) begin
        hold_started = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      stall_now = (hold_left > 0) || ($urandom_range(99) < recv_stall_pct);
      if (hold_left > 0) hold_left--;
      out_stall <= stall_now;
    end
  end

  // watchdog on beats of any kind
  always @(posedge clk) begin : watchdog
    int quiet;
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [DATA_W-1:0] rb_w, bpp_w, rows_w;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // registers as reset: one-byte rows, one-row images; unknown filter first
    pending_bytes = '{8'hff, 8'h12, pngunf_pkg::FILT_SUB, 8'h34};
    wait_idle();

    // every filter type once, extreme bytes, two-byte rows
    write_config(3'b111, 16'd2, 16'd1, 16'd6);
    pending_bytes = '{pngunf_pkg::FILT_NONE, 8'h00, 8'hff,
                      pngunf_pkg::FILT_SUB, 8'hff, 8'h01,
                      pngunf_pkg::FILT_UP, 8'h80, 8'h7f,
                      pngunf_pkg::FILT_AVG, 8'hff, 8'hff,
                      pngunf_pkg::FILT_PAETH, 8'h01, 8'hfe,
                      8'd5, 8'haa, 8'h55};
    wait_idle();

    // writes in mid-row: shorter row already passed, row count already past
    write_config(3'b111, 16'd4, 16'd1, 16'hffff);
    pending_bytes = '{pngunf_pkg::FILT_AVG, 8'h10, 8'hf0, 8'h33, 8'hcc,
                      pngunf_pkg::FILT_PAETH, 8'h5a, 8'ha5, 8'h0f};
    wait_idle();
    write_config(3'b101, 16'd2, 16'd0, 16'd1);
    pending_bytes.push_back(8'h77);
    wait_idle();

    // random images under each idling mix
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      if (ph == 1) begin
        rb_w = '0;
        bpp_w = '0;
        rows_w = '0;
      end else begin
        rb_w = DATA_W'($urandom_range(0, 40));
        bpp_w = DATA_W'($urandom_range(0, 15));
        rows_w = DATA_W'($urandom_range(0, 5));
      end
      write_config(3'b111, rb_w, bpp_w, rows_w);
      if (ph == 4) long_hold <= 1'b1;
      queue_images(rb_w, rows_w, (ph == 4) ? 160 : 40);
      wait_idle();
    end

    // widest pixels, clamped from an oversized value, over two rows
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_config(3'b111, 16'd60, 16'hffff, 16'd2);
    queue_images(16'd60, 16'd2, 1);
    wait_idle();

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
